@@ rtl/core/ibce_pkg.sv @@
// ----------------------------------------------------------------------------
// ibce_pkg
// Shared widths, register indexes, lane control and helpers for the IMU bias
// calibration and smoothing filter.
// ----------------------------------------------------------------------------
package ibce_pkg;

  localparam int CAL_SAMPLES = 500;
  localparam int CAL_W       = 16;
  localparam int CAL_HALF    = CAL_SAMPLES / 2;

  localparam int AXES        = 6;
  localparam int SMP_W       = 16;
  localparam int SUM_W       = 32;
  localparam int OFF_W       = 18;
  localparam int OUT_W       = 18;
  localparam int FILT_W      = 34;
  localparam int FRAC_W      = 16;
  localparam int BETA_W      = 16;
  localparam int GRAV_W      = 15;
  localparam int RND_HALF    = 1 << (FRAC_W - 1);

  localparam int DIV_STEPS   = 1;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 2);

  // average by reciprocal multiply: dividend below 2^DVD_W, exact floor
  localparam int DVD_W       = $clog2(longint'(CAL_SAMPLES) * (longint'(1) <<< (SMP_W - 1))
                                      + CAL_HALF + 1);
  localparam int RCP_SH      = DVD_W + $clog2(CAL_SAMPLES);
  localparam int RCP_W       = DVD_W + 1;
  localparam logic [RCP_W-1:0] DIV_RCP =
    RCP_W'(((longint'(1) <<< RCP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BETA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRAV = CFG_IDX_W'(1);

  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(6554);
  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(16384);

  localparam int AXIS_ACCEL_X = 0;
  localparam int AXIS_ACCEL_Y = 1;
  localparam int AXIS_ACCEL_Z = 2;
  localparam int AXIS_GYRO_X  = 3;
  localparam int AXIS_GYRO_Y  = 4;
  localparam int AXIS_GYRO_Z  = 5;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic signed [FILT_W-1:0] filt_t;

  typedef enum logic [1:0] {
    PH_CAL,
    PH_DIV,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic div_done;
    logic filt_en;
  } lane_ctl_t;

  typedef struct packed {
    out_t smooth_accel_x;
    out_t smooth_accel_y;
    out_t smooth_accel_z;
    out_t smooth_gyro_x;
    out_t smooth_gyro_y;
    out_t smooth_gyro_z;
  } res_t;

  // round filter state to counts, saturate to the output range
  function automatic out_t round_out(input filt_t f);
    logic signed [FILT_W:0]        r;
    logic signed [FILT_W-FRAC_W:0] q;
    r = (FILT_W+1)'(f) + (FILT_W+1)'(RND_HALF);
    q = r[FILT_W:FRAC_W];
    if (&q[FILT_W-FRAC_W:OUT_W-1] || ~|q[FILT_W-FRAC_W:OUT_W-1]) begin
      return q[OUT_W-1:0];
    end else if (q[FILT_W-FRAC_W]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/core/ibce_if.sv @@
// ----------------------------------------------------------------------------
// ibce channel interfaces
// Valid/ready channels for sample beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface ibce_in_if import ibce_pkg::*; ();
  logic valid;
  logic ready;
  smp_t accel_x;
  smp_t accel_y;
  smp_t accel_z;
  smp_t gyro_x;
  smp_t gyro_y;
  smp_t gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface ibce_out_if import ibce_pkg::*; ();
  logic valid;
  logic ready;
  out_t smooth_accel_x;
  out_t smooth_accel_y;
  out_t smooth_accel_z;
  out_t smooth_gyro_x;
  out_t smooth_gyro_y;
  out_t smooth_gyro_z;

  modport source (output valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
                  smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, input ready);
  modport sink   (input valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
                  smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, output ready);
endinterface

interface ibce_cfg_if import ibce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ibce_lane.sv @@
// ----------------------------------------------------------------------------
// ibce_lane
// One axis: calibration sum, reciprocal-multiply offset divider, offset
// removal and first-order smoothing filter.
// ----------------------------------------------------------------------------
module ibce_lane import ibce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl,
  input  smp_t              sample,
  input  logic [BETA_W-1:0] beta,
  input  logic [GRAV_W-1:0] grav,
  output filt_t             filt_nxt
);

  localparam int PROD_W = FILT_W + BETA_W + 2;
  localparam int STEP_W = PROD_W - FRAC_W;

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]         mag;
  logic [DVD_W-1:0]         dvd_r;
  logic [DVD_W+RCP_W-1:0]   qprod;
  logic [OFF_W-1:0]         quo_r;
  logic                     neg_r;
  logic signed [OFF_W-1:0]  off_r;
  logic signed [OFF_W-1:0]  quot;
  logic signed [OFF_W-1:0]  off_nxt;
  filt_t                    filt_r;

  logic signed [OFF_W:0]    diff;
  logic signed [OFF_W-1:0]  x;
  logic signed [FILT_W:0]   d;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W:0]   fsum;

  // calibration sum and divider operands
  always_comb begin
    sum_nxt = sum_r + SUM_W'(sample);
    mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    qprod   = dvd_r * DIV_RCP;
    quot    = quo_r;
    off_nxt = (neg_r ? -quot : quot) - OFF_W'({1'b0, grav});
  end

  // offset removal and filter step
  always_comb begin
    diff = (OFF_W+1)'(sample) - (OFF_W+1)'(off_r);
    if (diff[OFF_W] == diff[OFF_W-1]) begin
      x = diff[OFF_W-1:0];
    end else if (diff[OFF_W]) begin
      x = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      x = {1'b0, {(OFF_W-1){1'b1}}};
    end
    d    = (FILT_W+1)'($signed({x, {FRAC_W{1'b0}}})) - (FILT_W+1)'(filt_r);
    prod = d * $signed({1'b0, beta});
    rnd  = prod + PROD_W'(RND_HALF);
    step = rnd[PROD_W-1:FRAC_W];
    fsum = (STEP_W+1)'(filt_r) + (STEP_W+1)'(step);
    if (&fsum[STEP_W:FILT_W-1] || ~|fsum[STEP_W:FILT_W-1]) begin
      filt_nxt = fsum[FILT_W-1:0];
    end else if (fsum[STEP_W]) begin
      filt_nxt = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      filt_nxt = {1'b0, {(FILT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      off_r  <= '0;
      filt_r <= '0;
    end else begin
      if (ctl.acc_en) begin
        sum_r <= sum_nxt;
      end
      if (ctl.div_done) begin
        off_r <= off_nxt;
      end
      if (ctl.filt_en) begin
        filt_r <= filt_nxt;
      end
    end
  end

  // rounded magnitude, then one registered reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      dvd_r <= DVD_W'(mag + SUM_W'(CAL_HALF));
      neg_r <= sum_r[SUM_W-1];
    end else if (ctl.div_step) begin
      quo_r <= OFF_W'(qprod >> RCP_SH);
    end
  end

endmodule

@@ rtl/core/ibce_merge.sv @@
// ----------------------------------------------------------------------------
// ibce_merge
// Collects the six lane filter values into one result beat, with an output
// register and a skid register, and rounds them to counts.
// ----------------------------------------------------------------------------
module ibce_merge import ibce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  filt_t up_filt [AXES],
  output logic  dn_valid,
  input  logic  dn_ready,
  output res_t  dn_res
);

  filt_t main_r [AXES];
  filt_t skid_r [AXES];
  logic  main_v_r;
  logic  skid_v_r;
  logic  up_acc;
  logic  drain;

  assign up_ready = !skid_v_r;
  assign up_acc   = up_valid && up_ready;
  assign drain    = !main_v_r || dn_ready;
  assign dn_valid = main_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (drain) begin
      main_v_r <= skid_v_r || up_acc;
      skid_v_r <= 1'b0;
    end else if (up_acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      main_r <= skid_v_r ? skid_r : up_filt;
    end else if (up_acc) begin
      skid_r <= up_filt;
    end
  end

  assign dn_res.smooth_accel_x = round_out(main_r[AXIS_ACCEL_X]);
  assign dn_res.smooth_accel_y = round_out(main_r[AXIS_ACCEL_Y]);
  assign dn_res.smooth_accel_z = round_out(main_r[AXIS_ACCEL_Z]);
  assign dn_res.smooth_gyro_x  = round_out(main_r[AXIS_GYRO_X]);
  assign dn_res.smooth_gyro_y  = round_out(main_r[AXIS_GYRO_Y]);
  assign dn_res.smooth_gyro_z  = round_out(main_r[AXIS_GYRO_Z]);

endmodule

@@ rtl/core/imu_bias_calibrate_ema_filter.sv @@
// ----------------------------------------------------------------------------
// imu_bias_calibrate_ema_filter
// IMU bias calibration followed by a per-axis exponential moving average.
// ----------------------------------------------------------------------------
// After reset the first CAL_SAMPLES sample beats are summed per axis, one beat
// per cycle, and give no result. The last of them starts the offset divide:
// each of the six lanes scales its rounded sum by a fixed reciprocal of
// CAL_SAMPLES in one registered multiply step, and the input is held off
// until the offset is registered. The gravity count in effect at the last
// calibration beat is taken off the accel Z offset. From then on every sample
// beat is taken while the merge has room and gives one result beat; the six
// per-axis filter updates (one 35x17 multiply each) are combinational. Results
// pass through an output register and a skid register, so input keeps flowing
// while one result waits. Register writes are always taken, one per cycle.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_ema_filter import ibce_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  ibce_in_if.sink       in_bus,
  ibce_out_if.source    out_bus,
  ibce_cfg_if.sink      cfg_bus
);

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [CAL_W-1:0]       cnt_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [BETA_W-1:0]      beta_r;
  logic [GRAV_W-1:0]      grav_r;
  logic [GRAV_W-1:0]      grav_lat_r;
  logic                   in_acc;
  logic                   cal_last;
  logic                   div_end;
  logic                   mrg_ready;
  lane_ctl_t              ctl;
  smp_t                   samp [AXES];
  filt_t                  lane_filt [AXES];
  res_t                   res;

  assign samp[AXIS_ACCEL_X] = in_bus.accel_x;
  assign samp[AXIS_ACCEL_Y] = in_bus.accel_y;
  assign samp[AXIS_ACCEL_Z] = in_bus.accel_z;
  assign samp[AXIS_GYRO_X]  = in_bus.gyro_x;
  assign samp[AXIS_GYRO_Y]  = in_bus.gyro_y;
  assign samp[AXIS_GYRO_Z]  = in_bus.gyro_z;

  assign in_bus.ready = (phase_r == PH_CAL) || ((phase_r == PH_RUN) && mrg_ready);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign cal_last     = cnt_r == CAL_W'(CAL_SAMPLES - 1);
  assign div_end      = div_cnt_r == DIV_CNT_W'(DIV_STEPS + 1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_CAL: begin
        if (in_acc && cal_last) begin
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        if (div_end) begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: phase_nxt = PH_RUN;
      default: phase_nxt = PH_CAL;
    endcase
  end

  // lane controls
  always_comb begin
    ctl = '0;
    case (phase_r)
      PH_CAL: ctl.acc_en = in_acc;
      PH_DIV: begin
        ctl.div_load = div_cnt_r == '0;
        ctl.div_step = (div_cnt_r != '0) && !div_end;
        ctl.div_done = div_end;
      end
      PH_RUN: ctl.filt_en = in_acc;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CAL;
      cnt_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (ctl.acc_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (phase_r == PH_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en && cal_last) begin
      grav_lat_r <= grav_r;
    end
  end

  // register writes
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RESET;
      grav_r <= GRAV_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        REG_BETA: beta_r <= cfg_bus.data[BETA_W-1:0];
        REG_GRAV: grav_r <= cfg_bus.data[GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    ibce_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample   (samp[g]),
      .beta     (beta_r),
      .grav     ((g == AXIS_ACCEL_Z) ? grav_lat_r : '0),
      .filt_nxt (lane_filt[g])
    );
  end

  ibce_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_bus.valid && (phase_r == PH_RUN)),
    .up_ready (mrg_ready),
    .up_filt  (lane_filt),
    .dn_valid (out_bus.valid),
    .dn_ready (out_bus.ready),
    .dn_res   (res)
  );

  assign out_bus.smooth_accel_x = res.smooth_accel_x;
  assign out_bus.smooth_accel_y = res.smooth_accel_y;
  assign out_bus.smooth_accel_z = res.smooth_accel_z;
  assign out_bus.smooth_gyro_x  = res.smooth_gyro_x;
  assign out_bus.smooth_gyro_y  = res.smooth_gyro_y;
  assign out_bus.smooth_gyro_z  = res.smooth_gyro_z;

  a_last_cal_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CAL && in_acc && cal_last) |=> (phase_r == PH_DIV && div_cnt_r == '0))
    else $error("last calibration beat did not start the offset divide");

  a_no_result_before_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (phase_r == PH_RUN))
    else $error("result beat before calibration finished");

  a_run_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RUN) |=> (phase_r == PH_RUN))
    else $error("left filtering phase");

  a_cal_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CAL && !in_acc) |=> $stable(cnt_r))
    else $error("calibration count moved without a beat");

endmodule

@@ test/imu_bias_ema_check.sv @@
// ----------------------------------------------------------------------------
// imu_bias_ema_check
// Watches the sample, result and register channels of the IMU bias and
// smoothing block. Keeps its own copy of the registers, the calibration sums,
// the offsets and the per-axis filter state, works out the smoothed beat that
// each accepted sample should give and compares every result beat, axis by
// axis, with the oldest one still due.
// ----------------------------------------------------------------------------
module imu_bias_ema_check import ibce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ibce_in_if   in_mon,
  ibce_out_if  out_mon,
  ibce_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   samples_seen,
  output int   results_seen
);

  localparam longint FILT_HI = (longint'(1) <<< (FILT_W - 1)) - 1;
  localparam longint FILT_LO = -(longint'(1) <<< (FILT_W - 1));
  localparam longint OUT_HI  = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO  = -(longint'(1) <<< (OUT_W - 1));

  logic [BETA_W-1:0]       beta;
  logic [GRAV_W-1:0]       grav;
  logic                    calibrating;
  logic [CAL_W-1:0]        cal_count;
  logic signed [SUM_W-1:0] axis_sum [AXES];
  longint                  offset [AXES];
  longint                  filt [AXES];
  res_t                    smoothed_due [$];
  int                      errs = 0;
  int                      n_in = 0;
  int                      n_out = 0;
  string                   axis_name [AXES] = '{"smooth_accel_x", "smooth_accel_y",
                                                "smooth_accel_z", "smooth_gyro_x",
                                                "smooth_gyro_y", "smooth_gyro_z"};

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic calibrate_and_smooth(input longint s [AXES]);
    int     i;
    longint mag;
    longint x;
    longint d;
    longint f;
    res_t   r;
    r = '0;
    if (calibrating) begin
      for (i = 0; i < AXES; i++) begin
        axis_sum[i] = axis_sum[i] + SUM_W'(s[i]);
      end
      cal_count = cal_count + 1'b1;
      if (cal_count >= CAL_W'(CAL_SAMPLES)) begin
        // average rounds half away from zero
        for (i = 0; i < AXES; i++) begin
          mag = axis_sum[i] < 0 ? -longint'(axis_sum[i]) : longint'(axis_sum[i]);
          mag = (mag + CAL_HALF) / CAL_SAMPLES;
          offset[i] = axis_sum[i] < 0 ? -mag : mag;
        end
        offset[AXIS_ACCEL_Z] -= longint'(grav);
        calibrating = 1'b0;
      end
    end else begin
      for (i = 0; i < AXES; i++) begin
        x = clip(s[i] - offset[i], OUT_LO, OUT_HI);
        d = (x <<< FRAC_W) - filt[i];
        f = clip(filt[i] + ((d * longint'(beta) + RND_HALF) >>> FRAC_W), FILT_LO, FILT_HI);
        filt[i] = f;
        r[(AXES-1-i)*OUT_W +: OUT_W] = OUT_W'(clip((f + RND_HALF) >>> FRAC_W, OUT_LO, OUT_HI));
      end
      smoothed_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    longint s [AXES];
    res_t   got;
    res_t   want;
    int     i;
    if (!rst_n) begin
      beta        = BETA_RESET;
      grav        = GRAV_RESET;
      calibrating = 1'b1;
      cal_count   = '0;
      for (i = 0; i < AXES; i++) begin
        axis_sum[i] = '0;
        offset[i]   = 0;
        filt[i]     = 0;
      end
      smoothed_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_BETA: beta = cfg_mon.data[BETA_W-1:0];
          REG_GRAV: grav = cfg_mon.data[GRAV_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.smooth_accel_x, out_mon.smooth_accel_y, out_mon.smooth_accel_z,
               out_mon.smooth_gyro_x, out_mon.smooth_gyro_y, out_mon.smooth_gyro_z};
        n_out++;
        if (smoothed_due.size() == 0) begin
          $error("result beat with nothing due: %h", got);
          errs++;
        end else begin
          want = smoothed_due.pop_front();
          for (i = 0; i < AXES; i++) begin
            if (got[(AXES-1-i)*OUT_W +: OUT_W] !== want[(AXES-1-i)*OUT_W +: OUT_W]) begin
              $error("%s: expected %0d, got %0d", axis_name[i],
                     $signed(want[(AXES-1-i)*OUT_W +: OUT_W]),
                     $signed(got[(AXES-1-i)*OUT_W +: OUT_W]));
              errs++;
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        s[AXIS_ACCEL_X] = in_mon.accel_x;
        s[AXIS_ACCEL_Y] = in_mon.accel_y;
        s[AXIS_ACCEL_Z] = in_mon.accel_z;
        s[AXIS_GYRO_X]  = in_mon.gyro_x;
        s[AXIS_GYRO_Y]  = in_mon.gyro_y;
        s[AXIS_GYRO_Z]  = in_mon.gyro_z;
        n_in++;
        calibrate_and_smooth(s);
      end
    end
    fail_count   <= errs;
    pending      <= smoothed_due.size();
    samples_seen <= n_in;
    results_seen <= n_out;
  end

endmodule

@@ test/tb_imu_bias_calibrate_ema_filter.sv @@
// ----------------------------------------------------------------------------
// tb_imu_bias_calibrate_ema_filter
// Drives the IMU bias and smoothing block through one calibration with
// register writes partway, forced rounding ties on the last calibration beat,
// a ramp from the zero filter state, field extremes at full-scale beta
// and long random runs with idling on both channels. Checking is done by
// imu_bias_ema_check beside the block.
// ----------------------------------------------------------------------------
module tb_imu_bias_calibrate_ema_filter;
  import ibce_pkg::*;

  localparam int     DRAIN_WAIT  = DIV_STEPS + 8;
  localparam int     RUN_PHASES  = 6;
  localparam int     PHASE_BEATS = 64;
  localparam int     IDLE_PCT    = 21;
  localparam int     CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_GRAV + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;
  localparam smp_t   S_MAX = 16'sh7fff;
  localparam smp_t   S_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    DRAW_NEAR,
    DRAW_FULL,
    DRAW_EDGE
  } draw_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   sink_ready = 1'b0;
  logic   steady = 1'b0;
  int     fail_count;
  int     pending;
  int     samples_seen;
  int     results_seen;
  int     cycles = 0;
  longint cal_sum [AXES];
  longint bias [AXES];

  ibce_in_if  in_bus ();
  ibce_out_if out_bus ();
  ibce_cfg_if cfg_bus ();

  assign out_bus.ready = sink_ready;

  imu_bias_calibrate_ema_filter uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  imu_bias_ema_check chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_mon      (cfg_bus),
    .fail_count   (fail_count),
    .pending      (pending),
    .samples_seen (samples_seen),
    .results_seen (results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_imu_bias_calibrate_ema_filter: done, errors");
      $finish;
    end
  end

  function automatic smp_t draw(input draw_t how, input longint center);
    longint v;
    case (how)
      DRAW_NEAR: v = center + longint'($urandom_range(0, 600)) - 300;
      DRAW_FULL: v = longint'(smp_t'($urandom()));
      default: begin
        case ($urandom_range(0, 3))
          0:       v = S_MIN;
          1:       v = S_MAX;
          2:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return smp_t'(v < S_MIN ? S_MIN : (v > S_MAX ? S_MAX : v));
  endfunction

  // valid stays up after a beat; the next call lowers it only for a gap
  task automatic send_sample(input smp_t v [AXES]);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.accel_x <= v[AXIS_ACCEL_X];
    in_bus.accel_y <= v[AXIS_ACCEL_Y];
    in_bus.accel_z <= v[AXIS_ACCEL_Z];
    in_bus.gyro_x  <= v[AXIS_GYRO_X];
    in_bus.gyro_y  <= v[AXIS_GYRO_Y];
    in_bus.gyro_z  <= v[AXIS_GYRO_Z];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every due result is out, then let the divide or pipe finish
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    smp_t              v [AXES];
    logic [GRAV_W-1:0] grav_cal;
    logic [BETA_W-1:0] beta_plan [RUN_PHASES];
    longint            r;
    int                i;
    int                k;
    int                ph;
    int                pick;

    in_bus.valid   <= 1'b0;
    in_bus.accel_x <= '0;
    in_bus.accel_y <= '0;
    in_bus.accel_z <= '0;
    in_bus.gyro_x  <= '0;
    in_bus.gyro_y  <= '0;
    in_bus.gyro_z  <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    rst_n          <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_BETA, CFG_DATA_W'($urandom()));
    write_reg(REG_GRAV, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));

    for (i = 0; i < AXES; i++) begin
      cal_sum[i] = 0;
      case ($urandom_range(0, 3))
        0:       bias[i] = S_MAX;
        1:       bias[i] = S_MIN;
        2:       bias[i] = longint'($urandom_range(0, 4000)) - 2000;
        default: bias[i] = longint'(smp_t'($urandom()));
      endcase
    end

    // calibration, with register writes halfway through
    for (k = 0; k < CAL_SAMPLES; k++) begin
      if (k == CAL_HALF) begin
        settle();
        case ($urandom_range(0, 3))
          0:       grav_cal = '0;
          1:       grav_cal = '1;
          2:       grav_cal = GRAV_RESET;
          default: grav_cal = GRAV_W'($urandom());
        endcase
        write_reg(REG_GRAV, {1'($urandom()), grav_cal});
        write_reg(REG_TOP, CFG_DATA_W'($urandom()));
        write_reg(REG_BETA, $urandom_range(0, 1) ? BETA_RESET : BETA_W'($urandom()));
      end
      for (i = 0; i < AXES; i++) begin
        v[i] = draw(DRAW_NEAR, bias[i]);
      end
      // last beat: land some axis sums exactly halfway between two averages
      if (k == CAL_SAMPLES - 1) begin
        for (i = 0; i < AXES; i++) begin
          if ($urandom_range(0, 1)) begin
            r = longint'($urandom_range(0, 20000)) - 10000;
            r += (CAL_HALF - (((cal_sum[i] + r) % CAL_SAMPLES) + CAL_SAMPLES) % CAL_SAMPLES
                  + CAL_SAMPLES) % CAL_SAMPLES;
            v[i] = smp_t'(r);
          end
        end
      end
      for (i = 0; i < AXES; i++) begin
        cal_sum[i] += v[i];
      end
      send_sample(v);
    end
    settle();

    // ramp up from the zero filter state
    for (k = 0; k < 4; k++) begin
      for (i = 0; i < AXES; i++) begin
        v[i] = 16'sd20000;
      end
      send_sample(v);
    end
    settle();

    // field extremes, beta at full scale so outputs follow the input
    write_reg(REG_BETA, '1);
    for (k = 0; k < 10; k++) begin
      for (i = 0; i < AXES; i++) begin
        case (k)
          0:       v[i] = '0;
          1:       v[i] = S_MAX;
          2:       v[i] = S_MIN;
          3:       v[i] = S_MAX;
          4:       v[i] = i[0] ? 16'sh5555 : 16'shaaaa;
          5:       v[i] = i[0] ? 16'shaaaa : 16'sh5555;
          6:       v[i] = i < 3 ? S_MAX : S_MIN;
          7:       v[i] = i < 3 ? S_MIN : S_MAX;
          8:       v[i] = -16'sd1;
          default: v[i] = 16'sd1;
        endcase
      end
      send_sample(v);
    end
    settle();

    // beta zero holds the filter, beta one barely moves it
    write_reg(REG_BETA, '0);
    for (k = 0; k < 6; k++) begin
      if (k == 3) begin
        settle();
        write_reg(REG_BETA, 16'd1);
      end
      for (i = 0; i < AXES; i++) begin
        v[i] = draw(DRAW_FULL, 0);
      end
      send_sample(v);
    end

    beta_plan[0] = BETA_RESET;
    beta_plan[1] = '1;
    beta_plan[2] = BETA_W'($urandom());
    beta_plan[3] = 16'd1;
    beta_plan[4] = BETA_W'($urandom());
    beta_plan[5] = BETA_W'($urandom_range(0, 4096));
    for (ph = 0; ph < RUN_PHASES; ph++) begin
      settle();
      write_reg(REG_BETA, beta_plan[ph]);
      write_reg(REG_GRAV, ph[0] ? 16'h7fff : CFG_DATA_W'($urandom()));
      steady <= (ph == 2);
      for (k = 0; k < PHASE_BEATS; k++) begin
        for (i = 0; i < AXES; i++) begin
          pick = $urandom_range(0, 19);
          v[i] = draw(pick < 4 ? DRAW_EDGE : (pick < 9 ? DRAW_NEAR : DRAW_FULL), bias[i]);
        end
        send_sample(v);
      end
      steady <= 1'b0;
    end
    settle();

    $display("covered %0d sample beats (%0d in calibration) and %0d smoothed beats",
             samples_seen, CAL_SAMPLES, results_seen);
    $display("beta at 0, 1, reset, full scale and random; rounding ties on random axes");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_imu_bias_calibrate_ema_filter: done, clean");
    end else begin
      $display("tb_imu_bias_calibrate_ema_filter: done, errors");
    end
    $finish;
  end

endmodule
